@@ rtl/category_priority_scheduler_unit_macros.svh @@
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; each user provides clk and rst in scope.
`ifndef CATEGORY_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define CATEGORY_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define CPS_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Check that cond holds in the cycle after trig.
`define CPS_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ rtl/cps_pkg.sv @@
// Constants, codes and types of the category priority scheduler.
// Used by category_priority_scheduler_unit and the testbench; depends on nothing.
package cps_pkg;

  localparam int NUM_CATEGORIES = 8;
  localparam int QUEUE_DEPTH    = 128;
  localparam int PRIORITY_BITS  = 8;
  localparam int ID_BITS        = 8;
  localparam int TIME_BITS      = 32;
  localparam int SCALE_BITS     = 16;
  localparam int SCALE_RESET    = 2;

  localparam int SEL_W     = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int BUDGET_W  = SCALE_BITS + NUM_CATEGORIES - 1;
  localparam int CMP_W     = (TIME_BITS > BUDGET_W) ? TIME_BITS : BUDGET_W;
  localparam int ENTRY_W   = PRIORITY_BITS + ID_BITS;
  localparam int RAM_AW    = SEL_W + IDX_W;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE,
    S_FIND,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

@@ rtl/category_priority_scheduler_unit.sv @@
// Channel  | Signals                         | Word
// ---------+---------------------------------+----------------------------------
// in       | s_tvalid s_tready s_tdata s_tuser | push/pop/tick request
// out      | m_tvalid m_tready m_tdata m_tuser | status, job id, category
// cfg      | cfg_valid cfg_ready cfg_data    | wait_budget_scale write
//
// Push, tick and the unused code go from the accepting cycle to the DONE state,
// which loads the result register.
// Pop goes from the accepting cycle to an aging scan of the categories from the top
// (one subtract and compare per category, stopping at the first aged one), then
// scans the queue of n jobs through the RAM read port, then closes the gap with a
// read and a write per job behind the chosen one, and then finishes.
// A pop that finds nothing goes from the full aging scan straight to the result.
// Reset is synchronous; the job RAM needs no clearing pass.
// The input is taken only while the sequencer is idle; a held result stalls
// completion of the next word, not its acceptance.
module category_priority_scheduler_unit
  import cps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // category[2:0] priority_req[10:3] job_id[18:11]
                                 // accept_mask[26:19], zero fill
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_job_id[7:0] out_category[10:8], zero fill
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  `include "category_priority_scheduler_unit_macros.svh"

  state_t state, state_next;

  logic [CNT_W-1:0]          counts   [NUM_CATEGORIES];
  logic [TIME_BITS-1:0]      last_srv [NUM_CATEGORIES];
  logic [TIME_BITS-1:0]      cur_time;
  logic [SCALE_BITS-1:0]     scale;
  logic [NUM_CATEGORIES-1:0] mask_r;
  logic [SEL_W-1:0]          pick;
  logic [SEL_W-1:0]          age_idx;
  logic [CNT_W-1:0]          issue_idx;
  logic                      rvalid;
  logic [IDX_W-1:0]          rd_idx_d;
  logic [PRIORITY_BITS-1:0]  best_prio;
  logic [IDX_W-1:0]          best_idx;
  logic [IDX_W-1:0]          sh_idx;
  logic                      sh_phase;
  status_t                   res_status;
  logic [7:0]                res_id;
  logic [2:0]                res_cat;

  // input fields
  action_t       in_action;
  logic [2:0]    in_cat;
  logic [7:0]    in_prio;
  logic [7:0]    in_id;
  logic [7:0]    in_mask;
  logic          in_acc;
  logic [SEL_W-1:0] in_sel;
  logic          push_ok;

  assign in_action = action_t'(s_tuser);
  assign in_cat    = s_tdata[2:0];
  assign in_prio   = s_tdata[10:3];
  assign in_id     = s_tdata[18:11];
  assign in_mask   = s_tdata[26:19];
  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign in_sel    = SEL_W'(in_cat);
  assign push_ok   = (32'(in_cat) < NUM_CATEGORIES) &&
                     (32'(counts[in_sel]) < QUEUE_DEPTH);
  assign cfg_ready = 1'b1;

  // RAM ports
  logic                ram_wr_en, ram_rd_en;
  logic [RAM_AW-1:0]   ram_wr_addr, ram_rd_addr;
  logic [ENTRY_W-1:0]  ram_wr_data, ram_rd_data;

  cps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // aging check of one category per cycle
  logic [TIME_BITS-1:0]      elapsed;
  logic [CMP_W-1:0]          budget;
  logic                      age_hit;
  logic [NUM_CATEGORIES-1:0] elig;
  logic [SEL_W-1:0]          fb_sel;
  logic                      fb_any;

  assign elapsed = cur_time - last_srv[age_idx];
  assign budget  = CMP_W'(scale) << age_idx;
  assign age_hit = elig[age_idx] && (CMP_W'(elapsed) > budget);

  always_comb begin
    fb_sel = '0;
    for (int i = NUM_CATEGORIES - 1; i >= 0; i--) begin
      elig[i] = mask_r[i] && (counts[i] != '0);
      if (elig[i]) begin
        fb_sel = SEL_W'(i);
      end
    end
    fb_any = |elig;
  end

  // queue scan and gap closing
  logic [CNT_W-1:0]         n_jobs;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic                     take_new;
  logic [IDX_W-1:0]         best_idx_nx;
  logic                     find_last;
  logic                     sh_more;

  assign n_jobs      = counts[pick];
  assign rd_prio     = ram_rd_data[ENTRY_W-1 -: PRIORITY_BITS];
  assign take_new    = (rd_idx_d == '0) || (rd_prio > best_prio);
  assign best_idx_nx = take_new ? rd_idx_d : best_idx;
  assign find_last   = rvalid && ((CNT_W'(rd_idx_d) + CNT_W'(1)) == n_jobs);
  assign sh_more     = (CNT_W'(sh_idx) + CNT_W'(1)) < n_jobs;

  // next state and RAM controls
  always_comb begin
    state_next  = state;
    ram_wr_en   = 1'b0;
    ram_wr_addr = {in_sel, counts[in_sel][IDX_W-1:0]};
    ram_wr_data = {PRIORITY_BITS'(in_prio), ID_BITS'(in_id)};
    ram_rd_en   = 1'b0;
    ram_rd_addr = {pick, issue_idx[IDX_W-1:0]};
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (in_action == ACT_POP) ? S_AGE : S_DONE;
          ram_wr_en  = (in_action == ACT_PUSH) && push_ok;
        end
      end
      S_AGE: begin
        if (age_hit) begin
          state_next = S_FIND;
        end else if (age_idx == '0) begin
          state_next = fb_any ? S_FIND : S_DONE;
        end
      end
      S_FIND: begin
        ram_rd_en = (issue_idx < n_jobs);
        if (find_last) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!sh_phase) begin
          ram_rd_en   = sh_more;
          ram_rd_addr = {pick, sh_idx + IDX_W'(1)};
          if (!sh_more) begin
            state_next = S_DONE;
          end
        end else begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = {pick, sh_idx};
          ram_wr_data = ram_rd_data;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
        counts[i]   <= '0;
        last_srv[i] <= '0;
      end
      cur_time <= '0;
      scale    <= SCALE_BITS'(SCALE_RESET);
      m_tvalid <= 1'b0;
      rvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scale <= cfg_data;
      end
      // load a new result, else drop the result once taken
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      rvalid <= (state == S_FIND) && ram_rd_en;
      unique case (state)
        S_IDLE: begin
          if (in_acc && in_action == ACT_PUSH && push_ok) begin
            counts[in_sel] <= counts[in_sel] + CNT_W'(1);
          end
          if (in_acc && in_action == ACT_TICK) begin
            cur_time <= cur_time + TIME_BITS'(1);
          end
        end
        S_SHIFT: begin
          if (!sh_phase && !sh_more) begin
            counts[pick]   <= counts[pick] - CNT_W'(1);
            last_srv[pick] <= cur_time;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        res_status <= (in_acc && in_action == ACT_PUSH && !push_ok) ? STAT_FULL : STAT_OK;
        res_id     <= '0;
        res_cat    <= '0;
        mask_r     <= NUM_CATEGORIES'(in_mask);
        age_idx    <= SEL_W'(NUM_CATEGORIES - 1);
        issue_idx  <= '0;
        sh_phase   <= 1'b0;
      end
      S_AGE: begin
        if (age_hit) begin
          pick <= age_idx;
        end else if (age_idx == '0) begin
          pick <= fb_sel;
          if (!fb_any) begin
            res_status <= STAT_EMPTY;
          end
        end
        age_idx <= age_idx - SEL_W'(1);
      end
      S_FIND: begin
        if (ram_rd_en) begin
          issue_idx <= issue_idx + CNT_W'(1);
        end
        rd_idx_d <= issue_idx[IDX_W-1:0];
        if (rvalid) begin
          if (take_new) begin
            best_prio <= rd_prio;
            res_id    <= 8'(ram_rd_data[ID_BITS-1:0]);
          end
          best_idx <= best_idx_nx;
          sh_idx   <= best_idx_nx;
        end
      end
      S_SHIFT: begin
        sh_phase <= !sh_phase;
        if (sh_phase) begin
          sh_idx <= sh_idx + IDX_W'(1);
        end
        if (!sh_phase && !sh_more) begin
          res_cat <= 3'(pick);
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {5'd0, res_cat, res_id};
          m_tuser <= res_status;
        end
      end
      default: ;
    endcase
  end

  `CPS_ASSERT_SAME(a_find_nonempty, state == S_FIND, n_jobs != '0,
    "queue scan on an empty category")
  `CPS_ASSERT_SAME(a_shift_in_range, state == S_SHIFT, CNT_W'(sh_idx) < n_jobs,
    "gap index beyond queue fill")
  `CPS_ASSERT_NEXT(a_push_fill, in_acc && in_action == ACT_PUSH && push_ok,
    counts[$past(in_sel)] == $past(counts[in_sel]) + CNT_W'(1),
    "accepted push did not grow its queue")
  `CPS_ASSERT_SAME(a_busy_not_ready, state != S_IDLE, !s_tready,
    "input taken while sequencer busy")

endmodule

@@ rtl/cps_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module cps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ tb/sv/category_priority_scheduler_unit_test.sv @@
// Self-checking testbench for category_priority_scheduler_unit.
// Drives push/pop/tick words (and the unused code) and predicts every result with a scoreboard class.
// Depends on cps_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module category_priority_scheduler_unit_test;
  import cps_pkg::*;

  // Tracks the per-category queues, the aging clock and the results still owed
  class sched_scoreboard;
    typedef struct {
      logic [PRIORITY_BITS-1:0] prio;
      logic [ID_BITS-1:0]       id;
    } job_t;
    typedef struct {
      status_t     st;
      logic [7:0]  id;
      logic [2:0]  cat;
    } result_t;

    job_t        jobs[NUM_CATEGORIES][$];
    logic [31:0] now;
    logic [31:0] last_pop[NUM_CATEGORIES];
    logic [15:0] scale;
    result_t     owed[$];
    int          errors;
    int          n_words, n_jobs, n_full, n_empty, n_aged;

    function new();
      scale = 16'(SCALE_RESET);
      now = 0;
      foreach (last_pop[i]) last_pop[i] = 0;
      errors = 0;
      n_words = 0; n_jobs = 0; n_full = 0; n_empty = 0; n_aged = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted word to the state and queue its result
    function void note_word(action_t act, logic [2:0] cat, logic [7:0] prio,
                            logic [7:0] id, logic [7:0] mask);
      result_t     r;
      job_t        j;
      int          pick, best;
      logic [31:0] elapsed, budget;
      r.st = STAT_OK; r.id = 0; r.cat = 0;
      pick = -1;
      n_words++;
      case (act)
        ACT_PUSH: begin
          if (jobs[cat].size() >= QUEUE_DEPTH) begin
            r.st = STAT_FULL;
            n_full++;
          end else begin
            j.prio = prio; j.id = id;
            jobs[cat].insert(jobs[cat].size(), j);
          end
        end
        ACT_POP: begin
          // aged scan from the top, then lowest allowed non-empty category
          for (int i = NUM_CATEGORIES - 1; i >= 0 && pick < 0; i--) begin
            if (mask[i] && jobs[i].size() != 0) begin
              elapsed = now - last_pop[i];
              budget = 32'(scale) << i;
              if (elapsed > budget) pick = i;
            end
          end
          if (pick >= 0) n_aged++;
          for (int i = 0; i < NUM_CATEGORIES && pick < 0; i++)
            if (mask[i] && jobs[i].size() != 0) pick = i;
          if (pick < 0) begin
            r.st = STAT_EMPTY;
            n_empty++;
          end else begin
            best = 0;
            for (int k = 1; k < jobs[pick].size(); k++)
              if (jobs[pick][k].prio > jobs[pick][best].prio) best = k;
            r.id = jobs[pick][best].id;
            r.cat = pick[2:0];
            jobs[pick].delete(best);
            last_pop[pick] = now;
            n_jobs++;
          end
        end
        ACT_TICK: now = now + 1;
        default: ;
      endcase
      owed.insert(owed.size(), r);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_word(status_t st, logic [7:0] id, logic [2:0] cat);
      result_t r;
      if (owed.size() == 0) begin
        $error("unexpected result word: status %0d id %0d category %0d", st, id, cat);
        errors++;
        return;
      end
      r = owed.pop_front();
      if (st !== r.st) begin
        $error("status: expected %0d, got %0d", r.st, st);
        errors++;
      end
      if (id !== r.id) begin
        $error("out_job_id: expected %0d, got %0d", r.id, id);
        errors++;
      end
      if (cat !== r.cat) begin
        $error("out_category: expected %0d, got %0d", r.cat, cat);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 3000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = 0;
  logic [1:0]  s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 0;

  sched_scoreboard sb = new();
  int  tx_idle_pct = 20;
  int  rx_idle_pct = 69;
  bit  hold_req = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  int  n_cfg = 0;

  category_priority_scheduler_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_word(status_t'(m_tuser), m_tdata[7:0], m_tdata[10:8]);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one word, wait for its acceptance, then maybe idle
  task automatic send_word(action_t act, logic [2:0] cat, logic [7:0] prio,
                           logic [7:0] id, logic [7:0] mask);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, mask, id, prio, cat};
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(act, cat, prio, id, mask);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Hold the sender until every owed result has arrived
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write the budget scale while the block is idle
  task automatic write_scale(logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.scale = value;
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_mask();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'hff;
    if (r < 75) return 8'($urandom);
    if (r < 80) return 8'h00;
    return 8'h01 << $urandom_range(7);
  endfunction

  initial begin
    int          fill_left;
    logic [2:0]  fill_cat;
    int          r;
    logic [2:0]  cat;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every action, ties, empty pops, aging
    send_word(ACT_POP,  3'd0, 8'd0,   8'd0,   8'hff);
    send_word(ACT_PUSH, 3'd0, 8'd0,   8'd0,   8'h00);
    send_word(ACT_PUSH, 3'd7, 8'd255, 8'd255, 8'h00);
    send_word(ACT_PUSH, 3'd7, 8'd255, 8'd17,  8'hff);
    send_word(ACT_PUSH, 3'd7, 8'd128, 8'd170, 8'h00);
    send_word(ACT_PUSH, 3'd1, 8'd85,  8'd85,  8'h00);
    send_word(ACT_PUSH, 3'd3, 8'd1,   8'd254, 8'h00);
    send_word(ACT_NONE, 3'd5, 8'd255, 8'd255, 8'hff);
    send_word(ACT_POP,  3'd0, 8'd0,   8'd0,   8'h00);
    send_word(ACT_POP,  3'd0, 8'd0,   8'd0,   8'h80);
    send_word(ACT_POP,  3'd0, 8'd0,   8'd0,   8'h80);
    repeat (5) send_word(ACT_TICK, 3'd0, 8'd0, 8'd0, 8'h00);
    send_word(ACT_POP,  3'd0, 8'd0,   8'd0,   8'hfe);
    send_word(ACT_POP,  3'd0, 8'd0,   8'd0,   8'hff);
    send_word(ACT_POP,  3'd0, 8'd0,   8'd0,   8'hff);
    send_word(ACT_POP,  3'd0, 8'd0,   8'd0,   8'hff);
    send_word(ACT_POP,  3'd0, 8'd0,   8'd0,   8'hff);

    write_scale(16'd0);
    fill_left = 0;
    fill_cat = 0;
    tx_idle_pct = 20;
    rx_idle_pct = 69;

    // Random part in phases of scale and idling
    for (int i = 0; i < 1530; i++) begin
      if (i == 300)  write_scale(16'd1);
      if (i == 500) begin
        tx_idle_pct = 69;
        rx_idle_pct = 20;
      end
      if (i == 600)  hold_req = 1;
      if (i == 700)  write_scale(16'hffff);
      if (i == 900)  drain();
      if (i == 1000) begin
        write_scale(16'd3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (i == 1250) write_scale(16'($urandom_range(0, 8)));
      if (i == 100 || i == 1050) begin
        fill_left = QUEUE_DEPTH + 6;
        fill_cat = 3'($urandom_range(7));
      end

      if (fill_left > 0) begin
        fill_left--;
        send_word(ACT_PUSH, fill_cat, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        r = $urandom_range(99);
        cat = (r[0]) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
        if (r < 42)
          send_word(ACT_PUSH, cat, ($urandom_range(3) == 0) ? 8'($urandom_range(3))
                    : 8'($urandom), 8'($urandom), 8'($urandom));
        else if (r < 78)
          send_word(ACT_POP, 3'($urandom), 8'($urandom), 8'($urandom), rand_mask());
        else if (r < 96)
          send_word(ACT_TICK, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else
          send_word(ACT_NONE, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    drain();
    repeat (500) @(posedge clk);

    $display("covered %0d words, %0d scale writes: %0d jobs served (%0d by aging),",
             sb.n_words, n_cfg, sb.n_jobs, sb.n_aged);
    $display("%0d pops found nothing, %0d pushes hit a full queue",
             sb.n_empty, sb.n_full);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
